// File: hw/rtl/assert_macros.svh
// Assertion macros used by ppc_instruction_encoder.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
// Assert an implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`endif

// File: hw/rtl/ppce_pkg.sv
// Package: opcode table, form table and error codes of the instruction encoder.
package ppce_pkg;

	typedef enum logic [2:0] {
		ERR_OK = 3'd0, ERR_KIND = 3'd1, ERR_WIDE = 3'd2, ERR_PC = 3'd3,
		ERR_TGT = 3'd4, ERR_ABS = 3'd5, ERR_RANGE = 3'd6, ERR_NOENC = 3'd7
	} err_t;

	typedef enum logic [4:0] {
		F_DAB, F_DA, F_ASB, F_DASIMM, F_ASUIMM, F_BL, F_BS, F_BOBI, F_CRFDAB,
		F_CRFDCRFS, F_CRFDASIMM, F_CRFDAUIMM, F_AS, F_CRBDAB, F_AB, F_EXT,
		F_SHMBME, F_ASBMBME
	} form_t;

	typedef enum logic [2:0] {IM_NONE, IM_SIMM, IM_UIMM, IM_LONG, IM_SHORT} imm_t;

	localparam int NumOps = 140;

	typedef struct packed {
		form_t       form;
		logic [5:0]  prim;
		logic [9:0]  ext;
		logic        oe;
		logic        rc;
		logic        aa;
		logic        lk;
		logic        valid;
	} op_desc_t;

	typedef struct packed {
		logic [2:0]      nk;
		logic [4:0][2:0] kind;
		logic [2:0]      nf;
		logic [4:0][2:0] src;
		logic [4:0][4:0] lsb;
		logic [4:0][2:0] width;
		imm_t            imm;
	} form_desc_t;

	function automatic op_desc_t mk(form_t f, logic [5:0] p, logic [9:0] x, logic [3:0] fl);
		op_desc_t d;
		d.form = f; d.prim = p; d.ext = x;
		d.oe = fl[0]; d.rc = fl[1]; d.aa = fl[2]; d.lk = fl[3]; d.valid = 1'b1;
		return d;
	endfunction

	// Look up one mnemonic; groups of variants share an entry with flag bits.
	function automatic op_desc_t op_lookup(logic [7:0] c);
		op_desc_t d;
		logic [1:0] q;
		logic [1:0] qa;
		logic       p;
		d = '0;
		q = c[1:0];
		qa = c[1:0] - 2'd1;
		p = c[0];
		if (c < 8'd4) d = mk(F_DAB, 6'd31, 10'd266, {2'b0, q[0], q[1]});
		else if (c < 8'd8) d = mk(F_DAB, 6'd31, 10'd10, {2'b0, q[0], q[1]});
		else if (c < 8'd12) d = mk(F_DAB, 6'd31, 10'd138, {2'b0, q[0], q[1]});
		else if (c == 8'd12) d = mk(F_DASIMM, 6'd14, 10'd0, 4'd0);
		else if (c == 8'd13) d = mk(F_DASIMM, 6'd12, 10'd0, 4'd0);
		else if (c == 8'd14) d = mk(F_DASIMM, 6'd13, 10'd0, 4'd0);
		else if (c == 8'd15) d = mk(F_DASIMM, 6'd15, 10'd0, 4'd0);
		else if (c < 8'd20) d = mk(F_DA, 6'd31, 10'd234, {2'b0, q[0], q[1]});
		else if (c < 8'd24) d = mk(F_DA, 6'd31, 10'd202, {2'b0, q[0], q[1]});
		else if (c < 8'd28) d = mk(F_DAB, 6'd31, 10'd491, {2'b0, q[0], q[1]});
		else if (c < 8'd32) d = mk(F_DAB, 6'd31, 10'd459, {2'b0, q[0], q[1]});
		else if (c < 8'd34) d = mk(F_DAB, 6'd31, 10'd75, {2'b0, p, 1'b0});
		else if (c < 8'd36) d = mk(F_DAB, 6'd31, 10'd11, {2'b0, p, 1'b0});
		else if (c == 8'd36) d = mk(F_DASIMM, 6'd7, 10'd0, 4'd0);
		else if (c < 8'd41) d = mk(F_DAB, 6'd31, 10'd235, {2'b0, qa[0], qa[1]});
		else if (c < 8'd45) d = mk(F_DA, 6'd31, 10'd104, {2'b0, qa[0], qa[1]});
		else if (c < 8'd49) d = mk(F_DAB, 6'd31, 10'd40, {2'b0, qa[0], qa[1]});
		else if (c < 8'd53) d = mk(F_DAB, 6'd31, 10'd8, {2'b0, qa[0], qa[1]});
		else if (c < 8'd57) d = mk(F_DAB, 6'd31, 10'd136, {2'b0, qa[0], qa[1]});
		else if (c == 8'd57) d = mk(F_DASIMM, 6'd8, 10'd0, 4'd0);
		else if (c < 8'd62) d = mk(F_DA, 6'd31, 10'd232, {2'b0, q[0], ~q[1]});
		else if (c < 8'd66) d = mk(F_DA, 6'd31, 10'd200, {2'b0, q[0], ~q[1]});
		else begin
			case (c)
				8'd66: d = mk(F_CRFDAB, 6'd31, 10'd0, 4'd0);
				8'd67: d = mk(F_CRFDASIMM, 6'd11, 10'd0, 4'd0);
				8'd68: d = mk(F_CRFDAB, 6'd31, 10'd32, 4'd0);
				8'd69: d = mk(F_CRFDAUIMM, 6'd10, 10'd0, 4'd0);
				8'd70: d = mk(F_ASB, 6'd31, 10'd28, 4'd0);
				8'd71: d = mk(F_ASB, 6'd31, 10'd28, 4'd2);
				8'd72: d = mk(F_ASB, 6'd31, 10'd60, 4'd0);
				8'd73: d = mk(F_ASB, 6'd31, 10'd60, 4'd2);
				8'd74: d = mk(F_ASUIMM, 6'd28, 10'd0, 4'd0);
				8'd75: d = mk(F_ASUIMM, 6'd29, 10'd0, 4'd0);
				8'd76: d = mk(F_AS, 6'd31, 10'd26, 4'd0);
				8'd77: d = mk(F_AS, 6'd31, 10'd26, 4'd2);
				8'd78: d = mk(F_ASB, 6'd31, 10'd284, 4'd0);
				8'd79: d = mk(F_ASB, 6'd31, 10'd284, 4'd2);
				8'd80: d = mk(F_AS, 6'd31, 10'd954, 4'd0);
				8'd81: d = mk(F_AS, 6'd31, 10'd954, 4'd2);
				8'd82: d = mk(F_AS, 6'd31, 10'd922, 4'd0);
				8'd83: d = mk(F_AS, 6'd31, 10'd922, 4'd2);
				8'd84: d = mk(F_ASB, 6'd31, 10'd476, 4'd0);
				8'd85: d = mk(F_ASB, 6'd31, 10'd476, 4'd2);
				8'd86: d = mk(F_ASB, 6'd31, 10'd124, 4'd0);
				8'd87: d = mk(F_ASB, 6'd31, 10'd124, 4'd2);
				8'd88: d = mk(F_ASB, 6'd31, 10'd444, 4'd0);
				8'd89: d = mk(F_ASB, 6'd31, 10'd444, 4'd2);
				8'd90: d = mk(F_ASB, 6'd31, 10'd412, 4'd0);
				8'd91: d = mk(F_ASB, 6'd31, 10'd412, 4'd2);
				8'd92: d = mk(F_ASUIMM, 6'd24, 10'd0, 4'd0);
				8'd93: d = mk(F_ASUIMM, 6'd25, 10'd0, 4'd0);
				8'd94: d = mk(F_ASB, 6'd31, 10'd316, 4'd0);
				8'd95: d = mk(F_ASB, 6'd31, 10'd316, 4'd2);
				8'd96: d = mk(F_ASUIMM, 6'd26, 10'd0, 4'd0);
				8'd97: d = mk(F_ASUIMM, 6'd27, 10'd0, 4'd0);
				8'd98: d = mk(F_SHMBME, 6'd20, 10'd0, 4'd0);
				8'd99: d = mk(F_SHMBME, 6'd20, 10'd0, 4'd2);
				8'd100: d = mk(F_SHMBME, 6'd21, 10'd0, 4'd0);
				8'd101: d = mk(F_SHMBME, 6'd21, 10'd0, 4'd2);
				8'd102: d = mk(F_ASBMBME, 6'd23, 10'd0, 4'd0);
				8'd103: d = mk(F_ASBMBME, 6'd23, 10'd0, 4'd2);
				8'd104: d = mk(F_EXT, 6'd31, 10'd854, 4'd0);
				8'd105: d = mk(F_EXT, 6'd19, 10'd150, 4'd0);
				8'd106: d = mk(F_DAB, 6'd31, 10'd20, 4'd0);
				8'd107: d = mk(F_DAB, 6'd31, 10'd150, 4'd2);
				8'd108: d = mk(F_EXT, 6'd31, 10'd598, 4'd0);
				8'd109: d = mk(F_BL, 6'd18, 10'd0, 4'd0);
				8'd110: d = mk(F_BL, 6'd18, 10'd0, 4'd4);
				8'd111: d = mk(F_BL, 6'd18, 10'd0, 4'd8);
				8'd112: d = mk(F_BL, 6'd18, 10'd0, 4'd12);
				8'd113: d = mk(F_BS, 6'd16, 10'd0, 4'd0);
				8'd114: d = mk(F_BS, 6'd16, 10'd0, 4'd4);
				8'd115: d = mk(F_BS, 6'd16, 10'd0, 4'd8);
				8'd116: d = mk(F_BS, 6'd16, 10'd0, 4'd12);
				8'd117: d = mk(F_BOBI, 6'd19, 10'd528, 4'd0);
				8'd118: d = mk(F_BOBI, 6'd19, 10'd528, 4'd8);
				8'd119: d = mk(F_BOBI, 6'd19, 10'd16, 4'd0);
				8'd120: d = mk(F_BOBI, 6'd19, 10'd16, 4'd8);
				8'd121: d = mk(F_CRBDAB, 6'd19, 10'd257, 4'd0);
				8'd122: d = mk(F_CRBDAB, 6'd19, 10'd129, 4'd0);
				8'd123: d = mk(F_CRBDAB, 6'd19, 10'd289, 4'd0);
				8'd124: d = mk(F_CRBDAB, 6'd19, 10'd225, 4'd0);
				8'd125: d = mk(F_CRBDAB, 6'd19, 10'd33, 4'd0);
				8'd126: d = mk(F_CRBDAB, 6'd19, 10'd449, 4'd0);
				8'd127: d = mk(F_CRBDAB, 6'd19, 10'd417, 4'd0);
				8'd128: d = mk(F_CRBDAB, 6'd19, 10'd193, 4'd0);
				8'd129: d = mk(F_CRFDCRFS, 6'd19, 10'd0, 4'd0);
				8'd130: d = mk(F_AB, 6'd31, 10'd86, 4'd0);
				8'd131: d = mk(F_AB, 6'd31, 10'd470, 4'd0);
				8'd132: d = mk(F_AB, 6'd31, 10'd54, 4'd0);
				8'd133: d = mk(F_AB, 6'd31, 10'd278, 4'd0);
				8'd134: d = mk(F_AB, 6'd31, 10'd246, 4'd0);
				8'd135: d = mk(F_AB, 6'd31, 10'd1014, 4'd0);
				8'd136: d = mk(F_AB, 6'd4, 10'd1014, 4'd0);
				8'd137: d = mk(F_AB, 6'd31, 10'd982, 4'd0);
				8'd138: d = mk(F_DAB, 6'd31, 10'd310, 4'd0);
				8'd139: d = mk(F_DAB, 6'd31, 10'd438, 4'd0);
				default: d = '0;
			endcase
		end
		return d;
	endfunction

	function automatic form_desc_t fd(logic [2:0] nk, logic [14:0] kind, logic [2:0] nf,
		logic [14:0] src, logic [24:0] lsb, logic [14:0] wd, imm_t im);
		form_desc_t d;
		d.nk = nk; d.kind = kind; d.nf = nf; d.src = src; d.lsb = lsb;
		d.width = wd; d.imm = im;
		return d;
	endfunction

	// Fields listed last to first: {f4, f3, f2, f1, f0}.
	function automatic form_desc_t form_lookup(form_t f);
		form_desc_t d;
		case (f)
			F_DAB: d = fd(3'd3, 15'd0, 3'd3, {3'd0, 3'd0, 3'd2, 3'd1, 3'd0},
				{5'd0, 5'd0, 5'd11, 5'd16, 5'd21}, {3'd0, 3'd0, 3'd5, 3'd5, 3'd5}, IM_NONE);
			F_DA: d = fd(3'd2, 15'd0, 3'd2, {3'd0, 3'd0, 3'd0, 3'd1, 3'd0},
				{5'd0, 5'd0, 5'd0, 5'd16, 5'd21}, {3'd0, 3'd0, 3'd0, 3'd5, 3'd5}, IM_NONE);
			F_ASB: d = fd(3'd3, 15'd0, 3'd3, {3'd0, 3'd0, 3'd2, 3'd0, 3'd1},
				{5'd0, 5'd0, 5'd11, 5'd16, 5'd21}, {3'd0, 3'd0, 3'd5, 3'd5, 3'd5}, IM_NONE);
			F_DASIMM: d = fd(3'd3, {3'd0, 3'd0, 3'd2, 3'd0, 3'd0}, 3'd2,
				{3'd0, 3'd0, 3'd0, 3'd1, 3'd0}, {5'd0, 5'd0, 5'd0, 5'd16, 5'd21},
				{3'd0, 3'd0, 3'd0, 3'd5, 3'd5}, IM_SIMM);
			F_ASUIMM: d = fd(3'd3, {3'd0, 3'd0, 3'd3, 3'd0, 3'd0}, 3'd2,
				{3'd0, 3'd0, 3'd0, 3'd0, 3'd1}, {5'd0, 5'd0, 5'd0, 5'd16, 5'd21},
				{3'd0, 3'd0, 3'd0, 3'd5, 3'd5}, IM_UIMM);
			F_BL: d = fd(3'd1, {3'd0, 3'd0, 3'd0, 3'd0, 3'd4}, 3'd0, 15'd0, 25'd0, 15'd0,
				IM_LONG);
			F_BS: d = fd(3'd3, {3'd0, 3'd0, 3'd4, 3'd1, 3'd1}, 3'd2,
				{3'd0, 3'd0, 3'd0, 3'd1, 3'd0}, {5'd0, 5'd0, 5'd0, 5'd16, 5'd21},
				{3'd0, 3'd0, 3'd0, 3'd5, 3'd5}, IM_SHORT);
			F_BOBI: d = fd(3'd2, {3'd0, 3'd0, 3'd0, 3'd1, 3'd1}, 3'd2,
				{3'd0, 3'd0, 3'd0, 3'd1, 3'd0}, {5'd0, 5'd0, 5'd0, 5'd16, 5'd21},
				{3'd0, 3'd0, 3'd0, 3'd5, 3'd5}, IM_NONE);
			F_CRFDAB: d = fd(3'd3, {3'd0, 3'd0, 3'd0, 3'd0, 3'd5}, 3'd3,
				{3'd0, 3'd0, 3'd2, 3'd1, 3'd0}, {5'd0, 5'd0, 5'd11, 5'd16, 5'd23},
				{3'd0, 3'd0, 3'd5, 3'd5, 3'd3}, IM_NONE);
			F_CRFDCRFS: d = fd(3'd2, {3'd0, 3'd0, 3'd0, 3'd5, 3'd5}, 3'd2,
				{3'd0, 3'd0, 3'd0, 3'd1, 3'd0}, {5'd0, 5'd0, 5'd0, 5'd18, 5'd23},
				{3'd0, 3'd0, 3'd0, 3'd3, 3'd3}, IM_NONE);
			F_CRFDASIMM: d = fd(3'd3, {3'd0, 3'd0, 3'd2, 3'd0, 3'd5}, 3'd2,
				{3'd0, 3'd0, 3'd0, 3'd1, 3'd0}, {5'd0, 5'd0, 5'd0, 5'd16, 5'd23},
				{3'd0, 3'd0, 3'd0, 3'd5, 3'd3}, IM_SIMM);
			F_CRFDAUIMM: d = fd(3'd3, {3'd0, 3'd0, 3'd3, 3'd0, 3'd5}, 3'd2,
				{3'd0, 3'd0, 3'd0, 3'd1, 3'd0}, {5'd0, 5'd0, 5'd0, 5'd16, 5'd23},
				{3'd0, 3'd0, 3'd0, 3'd5, 3'd3}, IM_UIMM);
			F_AS: d = fd(3'd2, 15'd0, 3'd2, {3'd0, 3'd0, 3'd0, 3'd0, 3'd1},
				{5'd0, 5'd0, 5'd0, 5'd16, 5'd21}, {3'd0, 3'd0, 3'd0, 3'd5, 3'd5}, IM_NONE);
			F_CRBDAB: d = fd(3'd3, {3'd0, 3'd0, 3'd6, 3'd6, 3'd6}, 3'd3,
				{3'd0, 3'd0, 3'd2, 3'd1, 3'd0}, {5'd0, 5'd0, 5'd11, 5'd16, 5'd21},
				{3'd0, 3'd0, 3'd5, 3'd5, 3'd5}, IM_NONE);
			F_AB: d = fd(3'd2, 15'd0, 3'd2, {3'd0, 3'd0, 3'd0, 3'd1, 3'd0},
				{5'd0, 5'd0, 5'd0, 5'd11, 5'd16}, {3'd0, 3'd0, 3'd0, 3'd5, 3'd5}, IM_NONE);
			F_SHMBME: d = fd(3'd5, {3'd1, 3'd1, 3'd1, 3'd0, 3'd0}, 3'd5,
				{3'd4, 3'd3, 3'd2, 3'd0, 3'd1}, {5'd1, 5'd6, 5'd11, 5'd16, 5'd21},
				{3'd5, 3'd5, 3'd5, 3'd5, 3'd5}, IM_NONE);
			F_ASBMBME: d = fd(3'd5, {3'd1, 3'd1, 3'd0, 3'd0, 3'd0}, 3'd5,
				{3'd4, 3'd3, 3'd2, 3'd0, 3'd1}, {5'd1, 5'd6, 5'd11, 5'd16, 5'd21},
				{3'd5, 3'd5, 3'd5, 3'd5, 3'd5}, IM_NONE);
			default: d = '0;
		endcase
		return d;
	endfunction

endpackage

// File: hw/rtl/ppce_core.sv
// Combinational encode of one registered request into word and error code.
module ppce_core (
	input  logic [7:0]       mnemonic_code,
	input  logic [14:0]      operand_kinds,
	input  logic [4:0][15:0] operands,
	input  logic [31:0]      immediate,
	input  logic [31:0]      current_pc,
	output logic [31:0]      instr_word,
	output ppce_pkg::err_t   error_code
);
	import ppce_pkg::*;

	op_desc_t   op;
	form_desc_t fm;
	logic       kind_bad;
	logic       wide_bad;
	logic [31:0] fields;
	logic [31:0] diff;
	logic [31:0] bfield;
	err_t        berr;
	logic        is_branch;
	logic [31:0] w;
	logic [15:0] v;

	assign op = op_lookup(mnemonic_code);
	assign fm = form_lookup(op.form);
	assign is_branch = (fm.imm == IM_LONG) || (fm.imm == IM_SHORT);
	assign diff = immediate - current_pc;

	// Check kinds and field widths, pack fields.
	always_comb begin
		kind_bad = 1'b0;
		wide_bad = 1'b0;
		fields = '0;
		v = '0;
		for (int i = 0; i < 5; i++) begin
			if (3'(i) < fm.nk && operand_kinds[3*i +: 3] != fm.kind[i]) kind_bad = 1'b1;
			if (3'(i) < fm.nf) begin
				v = operands[fm.src[i]];
				if ((v >> fm.width[i]) != 16'd0) wide_bad = 1'b1;
				fields = fields | ({16'd0, v} << fm.lsb[i]);
			end
		end
	end

	// Compute branch displacement and its checks.
	always_comb begin
		berr = ERR_OK;
		bfield = '0;
		if (current_pc[1:0] != 2'd0) berr = ERR_PC;
		else if (immediate[1:0] != 2'd0) berr = ERR_TGT;
		else if (fm.imm == IM_LONG) begin
			if (op.aa) begin
				if (immediate[31:25] != 7'h7F && immediate[31:25] != 7'h00) berr = ERR_ABS;
				bfield = immediate & 32'h03FF_FFFC;
			end else begin
				if (diff[31:25] != 7'h7F && diff[31:25] != 7'h00) berr = ERR_RANGE;
				bfield = diff & 32'h03FF_FFFC;
			end
		end else begin
			if (op.aa) begin
				if (immediate[31:15] != 17'h1FFFF && immediate[31:15] != 17'h0) berr = ERR_ABS;
				bfield = immediate & 32'h0000_FFFC;
			end else begin
				if (diff[31:15] != 17'h1FFFF && diff[31:15] != 17'h0) berr = ERR_RANGE;
				bfield = diff & 32'h0000_FFFC;
			end
		end
	end

	// Select first failing check and assemble word.
	always_comb begin
		w = {op.prim, 15'd0, op.ext, 1'b0} | fields;
		case (fm.imm)
			IM_SIMM: w = w | {16'd0, immediate[15:0]};
			IM_UIMM: w = w | immediate;
			IM_LONG, IM_SHORT: w = w | bfield;
			default: w = w;
		endcase
		w = w | {21'd0, op.oe, 8'd0, op.aa, op.rc | op.lk};
		error_code = ERR_OK;
		if (!op.valid) error_code = ERR_NOENC;
		else if (kind_bad) error_code = ERR_KIND;
		else if (is_branch && berr != ERR_OK) error_code = berr;
		else if (wide_bad) error_code = ERR_WIDE;
		else if (fm.imm == IM_UIMM && immediate[31:16] != 16'd0) error_code = ERR_WIDE;
		instr_word = (error_code == ERR_OK) ? w : 32'd0;
	end

endmodule

// File: hw/rtl/ppc_instruction_encoder.sv
// Path: the request passes through the input register, then the result register; out_ready can stall either.
// Throughput: one instruction per cycle while out_ready does not stall; the encode is opcode and form lookups and pack.
// A skid-free pipeline: each stage advances when the stage after it is empty or taken.
// Reset: arst_n clears the valid bits of both stages; payload registers are not reset.
module ppc_instruction_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  mnemonic_code,
	input  logic [14:0] operand_kinds,
	input  logic [15:0] operand_0,
	input  logic [15:0] operand_1,
	input  logic [15:0] operand_2,
	input  logic [15:0] operand_3,
	input  logic [15:0] operand_4,
	input  logic [31:0] immediate,
	input  logic [31:0] current_pc,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] instr_word,
	output logic [2:0]  error_code
);
	import ppce_pkg::*;
	`include "assert_macros.svh"

	logic             vld_s1, vld_s2;
	logic             adv_s1, adv_s2;
	logic [7:0]       code_s1;
	logic [14:0]      kinds_s1;
	logic [4:0][15:0] ops_s1;
	logic [31:0]      imm_s1, pc_s1;
	logic [31:0]      word_c, word_s2;
	err_t             err_c, err_s2;

	assign adv_s2 = !vld_s2 || out_ready;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign in_ready = adv_s1;

	// Hold the request in the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv_s1) vld_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			code_s1 <= mnemonic_code;
			kinds_s1 <= operand_kinds;
			ops_s1 <= {operand_4, operand_3, operand_2, operand_1, operand_0};
			imm_s1 <= immediate;
			pc_s1 <= current_pc;
		end
	end

	ppce_core u_core (
		.mnemonic_code(code_s1),
		.operand_kinds(kinds_s1),
		.operands     (ops_s1),
		.immediate    (imm_s1),
		.current_pc   (pc_s1),
		.instr_word   (word_c),
		.error_code   (err_c)
	);

	// Advance the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv_s2) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			word_s2 <= word_c;
			err_s2 <= err_c;
		end
	end

	assign out_valid = vld_s2;
	assign instr_word = word_s2;
	assign error_code = err_s2;

	`ASSERT_IMPL(a_err_word_zero, clk, arst_n, out_valid && error_code != ERR_OK, instr_word == 32'd0, "word not zero on error")
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(instr_word), "result lost under stall")
	`ASSERT_NEXT(a_fill, clk, arst_n, vld_s1 && adv_s2, out_valid, "stage one item not moved")

endmodule
